/* hw/rtl/cts_pkg.sv */
// Package: constants, codes, command/status types and helpers for the coloring search core.
package cts_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int ROW_W        = 64;
   localparam int ADJ_W        = MAX_VERTICES + CNT_W;
   localparam int ITER_W       = 40;
   localparam int VC_W         = 7;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 40;
   localparam int NUM_COLORS   = 3;
   localparam int MAX_USE      = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] OUT_FROZEN   = 2'd0;
   localparam logic [1:0] OUT_UNFROZEN = 2'd1;
   localparam logic [1:0] OUT_CAPPED   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_CAP     = 4'd1;

   typedef struct packed {
      logic       load_wr;
      logic       row_rd;
      logic       nbv_ld;
      logic       nb_scan;
      logic       deg_init;
      logic       sc_start;
      logic       sc_scan;
      logic       d_dec;
      logic       srch_init;
      logic       iter;
      logic       rd1;
      logic       rd2;
      logic       bk;
      logic       fin;
      logic [1:0] fin_code;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic u_last;
      logic present_d;
      logic d_zero;
      logic cap_hit;
      logic at_end;
      logic found;
      logic pos_zero;
      logic rsp_free;
   } status_type;

   function automatic logic [CNT_W-1:0] popcount_row(input logic [MAX_VERTICES-1:0] row);
      logic [CNT_W-1:0] total;
      logic [3:0]       part;
      total = '0;
      for (int b = 0; b < MAX_VERTICES; b += 8) begin
         part = '0;
         for (int k = 0; k < 8; k++) begin
            if (b + k < MAX_VERTICES) part = part + 4'(row[b+k]);
         end
         total = total + CNT_W'(part);
      end
      return total;
   endfunction

endpackage

/* hw/rtl/cts_if.sv */
// Interfaces: request, response and register write channels.
interface cts_req_if;
   import cts_pkg::*;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [VIDX_W-1:0] row_index;
   logic [ROW_W-1:0]  row_bits;
   logic [VIDX_W-1:0] query_vertex;
   modport source (output valid, operation, row_index, row_bits, query_vertex, input ready);
   modport sink (input valid, operation, row_index, row_bits, query_vertex, output ready);
endinterface

interface cts_rsp_if;
   import cts_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        outcome;
   logic [ITER_W-1:0] iterations_used;
   modport source (output valid, outcome, iterations_used, input ready);
   modport sink (input valid, outcome, iterations_used, output ready);
endinterface

interface cts_csr_if;
   import cts_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/cts_ram.sv */
// Generic RAM: one write port, one read port, registered read data.
module cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/cts_ctrl.sv */
// Controller: sequences row loads, search-order build and the backtracking search.
module cts_ctrl import cts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cts_req_if.sink    req_bus,
   output cmd_type    cmd,
   input  status_type stat
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ROWW = 4'd1;
   localparam logic [3:0] S_NB   = 4'd2;
   localparam logic [3:0] S_NBD  = 4'd3;
   localparam logic [3:0] S_DEG  = 4'd4;
   localparam logic [3:0] S_SC   = 4'd5;
   localparam logic [3:0] S_SCD  = 4'd6;
   localparam logic [3:0] S_ITER = 4'd7;
   localparam logic [3:0] S_RD1  = 4'd8;
   localparam logic [3:0] S_RD2  = 4'd9;
   localparam logic [3:0] S_BK   = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.operation == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.row_rd = 1'b1;
                  state_in   = S_ROWW;
               end
            end
         end
         S_ROWW: begin
            cmd.nbv_ld = 1'b1;
            state_in   = S_NB;
         end
         S_NB: begin
            cmd.nb_scan = 1'b1;
            if (stat.u_last) state_in = S_NBD;
         end
         S_NBD: begin
            cmd.deg_init = 1'b1;
            state_in     = S_DEG;
         end
         S_DEG: begin
            priority if (stat.present_d) begin
               cmd.sc_start = 1'b1;
               state_in     = S_SC;
            end else if (stat.d_zero) begin
               cmd.srch_init = 1'b1;
               state_in      = S_ITER;
            end else begin
               cmd.d_dec = 1'b1;
            end
         end
         S_SC: begin
            cmd.sc_scan = 1'b1;
            if (stat.u_last) state_in = S_SCD;
         end
         S_SCD: begin
            if (stat.d_zero) begin
               cmd.srch_init = 1'b1;
               state_in      = S_ITER;
            end else begin
               cmd.d_dec = 1'b1;
               state_in  = S_DEG;
            end
         end
         S_ITER: begin
            cmd.iter = 1'b1;
            priority if (stat.cap_hit) begin
               cmd.fin      = 1'b1;
               cmd.fin_code = OUT_CAPPED;
               state_in     = S_DONE;
            end else if (stat.at_end) begin
               cmd.fin      = 1'b1;
               cmd.fin_code = OUT_UNFROZEN;
               state_in     = S_DONE;
            end else begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd2 = 1'b1;
            priority if (stat.found) begin
               state_in = S_ITER;
            end else if (stat.pos_zero) begin
               cmd.fin      = 1'b1;
               cmd.fin_code = OUT_FROZEN;
               state_in     = S_DONE;
            end else begin
               state_in = S_BK;
            end
         end
         S_BK: begin
            cmd.bk   = 1'b1;
            state_in = S_ITER;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

/* hw/rtl/cts_datapath.sv */
// Datapath: adjacency/order/try memories, color masks, counters and result register.
module cts_datapath import cts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        stat,
   input  logic [VIDX_W-1:0] row_index,
   input  logic [ROW_W-1:0]  row_bits,
   input  logic [VIDX_W-1:0] query_vertex,
   cts_csr_if.sink           csr_bus,
   cts_rsp_if.source         rsp_bus
);
   logic [VC_W-1:0]         vc_ff, vc_in;
   logic [ITER_W-1:0]       cap_ff, cap_in;
   logic [VIDX_W-1:0]       v_ff, v_in;
   logic [MAX_VERTICES-1:0] nbv_ff, nbv_in;
   logic [VIDX_W-1:0]       u_ff, u_in, ud_ff, ud_in, x_ff, x_in;
   logic                    dv_ff, dv_in, dmode_ff, dmode_in, fresh_ff, fresh_in;
   logic [CNT_W-1:0]        m_ff, m_in, nn_ff, nn_in, d_ff, d_in, pos_ff, pos_in;
   logic [MAX_VERTICES:0]   present_ff, present_in;
   logic [ITER_W:0]         cnt_ff, cnt_in;
   logic [MAX_VERTICES-1:0] mask_ff [NUM_COLORS];
   logic [MAX_VERTICES-1:0] mask_in [NUM_COLORS];
   logic [1:0]              use_ff [NUM_COLORS];
   logic [1:0]              use_in [NUM_COLORS];
   logic [1:0]              c0_ff, c0_in, res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_out_ff, rsp_out_in;
   logic [ITER_W-1:0]       rsp_iter_ff, rsp_iter_in;

   logic                    adj_we;
   logic [VIDX_W-1:0]       adj_ra;
   logic [ADJ_W-1:0]        adj_wd, adj_q;
   logic                    ord_we;
   logic [VIDX_W-1:0]       ord_wa, ord_ra, ord_q;
   logic                    try_we;
   logic [VIDX_W-1:0]       try_ra;
   logic [1:0]              try_wd, try_q;

   logic [CNT_W-1:0]        limit, deg_q, pos_m1;
   logic                    elig;
   logic [MAX_VERTICES-1:0] conf, vbit, xbit, ybit;
   logic [NUM_COLORS-1:0]   ok;
   logic                    found;
   logic [1:0]              csel, cmax, cy;
   logic                    in_nb;

   assign limit  = (vc_ff > VC_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_ff);
   assign deg_q  = adj_q[ADJ_W-1:MAX_VERTICES];
   assign pos_m1 = pos_ff - CNT_W'(1);
   assign elig   = !nbv_ff[ud_ff] && (ud_ff != v_ff) && (CNT_W'(ud_ff) < limit);
   assign vbit   = MAX_VERTICES'(1) << v_ff;
   assign xbit   = MAX_VERTICES'(1) << x_ff;
   assign ybit   = MAX_VERTICES'(1) << ord_q;
   assign conf   = adj_q[MAX_VERTICES-1:0] & ~vbit;
   assign in_nb  = pos_ff < nn_ff;
   assign cmax   = (pos_ff == '0) ? 2'd1 : 2'd3;
   assign cy     = try_q - 2'd1;

   always_comb begin
      found = 1'b0;
      csel  = '0;
      for (int c = 0; c < NUM_COLORS; c++) begin
         ok[c] = (2'(c) >= c0_ff) && (2'(c) < cmax)
               && !(in_nb && use_ff[c] >= 2'(MAX_USE))
               && !(|(conf & mask_ff[c]));
      end
      for (int c = NUM_COLORS - 1; c >= 0; c--) begin
         if (ok[c]) begin
            found = 1'b1;
            csel  = 2'(c);
         end
      end
   end

   assign adj_we = cmd.load_wr;
   assign adj_wd = {popcount_row(row_bits[MAX_VERTICES-1:0]), row_bits[MAX_VERTICES-1:0]};

   always_comb begin
      priority if (cmd.row_rd) adj_ra = query_vertex;
      else if (cmd.rd1)        adj_ra = ord_q;
      else                     adj_ra = u_ff;
   end

   always_comb begin
      ord_we = 1'b0;
      ord_wa = m_ff[VIDX_W-1:0];
      if (cmd.nb_scan) begin
         ord_we = nbv_ff[u_ff];
      end else if (dv_ff && dmode_ff) begin
         ord_we = elig && (deg_q == d_ff);
      end
   end

   assign ord_ra = cmd.iter ? pos_ff[VIDX_W-1:0] : pos_m1[VIDX_W-1:0];
   assign try_ra = ord_ra;
   assign try_we = cmd.rd2 && found;
   assign try_wd = csel + 2'd1;

   cts_ram #(.WIDTH(ADJ_W), .DEPTH(MAX_VERTICES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(row_index), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_q));

   cts_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa),
      .wr_data(cmd.nb_scan ? u_ff : ud_ff), .rd_addr(ord_ra), .rd_data(ord_q));

   cts_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_try (
      .clock(clock), .wr_en(try_we), .wr_addr(pos_ff[VIDX_W-1:0]), .wr_data(try_wd),
      .rd_addr(try_ra), .rd_data(try_q));

   always_comb begin
      vc_in       = vc_ff;
      cap_in      = cap_ff;
      v_in        = v_ff;
      nbv_in      = nbv_ff;
      u_in        = u_ff;
      ud_in       = u_ff;
      dv_in       = cmd.nb_scan | cmd.sc_scan;
      dmode_in    = cmd.sc_scan;
      x_in        = x_ff;
      fresh_in    = fresh_ff;
      m_in        = m_ff;
      nn_in       = nn_ff;
      d_in        = d_ff;
      pos_in      = pos_ff;
      present_in  = present_ff;
      cnt_in      = cnt_ff;
      mask_in     = mask_ff;
      use_in      = use_ff;
      c0_in       = c0_ff;
      res_in      = res_ff;
      rsp_out_in  = rsp_out_ff;
      rsp_iter_in = rsp_iter_ff;

      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_VERTEX_COUNT) vc_in = csr_bus.data[VC_W-1:0];
         if (csr_bus.index == CSR_NODE_CAP)     cap_in = csr_bus.data[ITER_W-1:0];
      end

      if (cmd.row_rd) v_in = query_vertex;
      if (cmd.nbv_ld) begin
         nbv_in     = adj_q[MAX_VERTICES-1:0];
         u_in       = '0;
         m_in       = '0;
         nn_in      = '0;
         pos_in     = '0;
         present_in = '0;
      end
      if (cmd.sc_start) u_in = '0;
      if (cmd.nb_scan | cmd.sc_scan) u_in = u_ff + VIDX_W'(1);
      if (ord_we) m_in = m_ff + CNT_W'(1);
      if (dv_ff && !dmode_ff && elig) present_in[deg_q] = 1'b1;
      if (cmd.deg_init) begin
         d_in  = CNT_W'(MAX_VERTICES);
         nn_in = m_ff;
      end
      if (cmd.d_dec) d_in = d_ff - CNT_W'(1);

      if (cmd.srch_init) begin
         pos_in   = '0;
         cnt_in   = '0;
         fresh_in = 1'b1;
         for (int c = 0; c < NUM_COLORS; c++) begin
            mask_in[c] = '0;
            use_in[c]  = '0;
         end
      end
      if (cmd.iter) cnt_in = cnt_ff + (ITER_W+1)'(1);
      if (cmd.rd1) begin
         x_in  = ord_q;
         c0_in = fresh_ff ? 2'd0 : try_q;
      end
      if (cmd.rd2) begin
         if (found) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
               if (csel == 2'(c)) begin
                  mask_in[c] = mask_ff[c] | xbit;
                  if (in_nb) use_in[c] = use_ff[c] + 2'd1;
               end
            end
            pos_in   = pos_ff + CNT_W'(1);
            fresh_in = 1'b1;
         end else if (pos_ff != '0) begin
            pos_in = pos_m1;
         end
      end
      if (cmd.bk) begin
         for (int c = 0; c < NUM_COLORS; c++) begin
            if (cy == 2'(c)) begin
               mask_in[c] = mask_ff[c] & ~ybit;
               if (in_nb && use_ff[c] != 2'd0) use_in[c] = use_ff[c] - 2'd1;
            end
         end
         fresh_in = 1'b0;
      end
      if (cmd.fin) res_in = cmd.fin_code;
      if (cmd.push) begin
         rsp_out_in  = res_ff;
         rsp_iter_in = cnt_ff[ITER_W] ? '1 : cnt_ff[ITER_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push)         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= VC_W'(MAX_VERTICES);
         cap_ff       <= ITER_W'(500000000);
         dv_ff        <= 1'b0;
         dmode_ff     <= 1'b0;
         m_ff         <= '0;
         nn_ff        <= '0;
         d_ff         <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         fresh_ff     <= 1'b1;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_COLORS; c++) begin
            mask_ff[c] <= '0;
            use_ff[c]  <= '0;
         end
      end else begin
         vc_ff        <= vc_in;
         cap_ff       <= cap_in;
         dv_ff        <= dv_in;
         dmode_ff     <= dmode_in;
         m_ff         <= m_in;
         nn_ff        <= nn_in;
         d_ff         <= d_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
         use_ff       <= use_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      nbv_ff      <= nbv_in;
      u_ff        <= u_in;
      ud_ff       <= ud_in;
      x_ff        <= x_in;
      c0_ff       <= c0_in;
      res_ff      <= res_in;
      rsp_out_ff  <= rsp_out_in;
      rsp_iter_ff <= rsp_iter_in;
   end

   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.outcome         = rsp_out_ff;
   assign rsp_bus.iterations_used = rsp_iter_ff;

   assign stat.u_last    = (u_ff == VIDX_W'(MAX_VERTICES - 1));
   assign stat.present_d = present_ff[d_ff];
   assign stat.d_zero    = (d_ff == '0);
   assign stat.cap_hit   = (cnt_ff + (ITER_W+1)'(1)) > {1'b0, cap_ff};
   assign stat.at_end    = (pos_ff == m_ff);
   assign stat.found     = found;
   assign stat.pos_zero  = (pos_ff == '0);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   a_pos_le_m: assert property (@(posedge clock) disable iff (reset) pos_ff <= m_ff)
      else $error("search depth beyond order length");
   a_use_max: assert property (@(posedge clock) disable iff (reset)
      use_ff[0] <= 2'(MAX_USE) && use_ff[1] <= 2'(MAX_USE) && use_ff[2] <= 2'(MAX_USE))
      else $error("color use count over limit");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd2 && found) |=> pos_ff == $past(pos_ff) + CNT_W'(1))
      else $error("advance did not step depth");
endmodule

/* hw/rtl/constrained_three_coloring_search_core.sv */
// Top level: constrained 3-coloring search core.
// Load request: accepted while idle, no response; loads can follow back to back.
// Query: row read and neighbor scan, then per degree value a check (absent) or a
// vertex scan (present) for the order build, then ITER, RD1, RD2 per forward search
// step, plus BK per backtrack step, then the response. One query in flight at a time.
// Synchronous active-high reset; adjacency memory contents are undefined until loaded.
module constrained_three_coloring_search_core import cts_pkg::*; (
   input logic       clock,
   input logic       reset,
   cts_req_if.sink   req_bus,
   cts_rsp_if.source rsp_bus,
   cts_csr_if.sink   csr_bus
);
   cmd_type    cmd;
   status_type stat;

   cts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_bus(req_bus), .cmd(cmd), .stat(stat));

   cts_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .row_index(req_bus.row_index), .row_bits(req_bus.row_bits),
      .query_vertex(req_bus.query_vertex), .csr_bus(csr_bus), .rsp_bus(rsp_bus));
endmodule
